FILE: hw/rtl/tsde_pkg.sv
// ----------------------------------------------------------------------------
// Tab stop detab/entab package
// Shared constants for the tab expansion and compression block.
// ----------------------------------------------------------------------------
package tsde_pkg;

    localparam int MAX_STOPS_DEF  = 8;
    localparam int MAX_COLUMN_DEF = 255;

    localparam int CHAR_W    = 8;
    localparam int COL_W     = 8;
    localparam int CAND_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
    localparam logic [CHAR_W-1:0] TAB_RESET  = 8'd9;
    localparam logic [7:0]        IV_RESET   = 8'd8;

    localparam logic [7:0] LAST_SEARCH_K = 8'd254;
    localparam logic [7:0] MAX_K         = 8'd255;
    localparam logic [7:0] PEND_MAX      = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COLUMNS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_CHAR     = 3'd4;

endpackage

FILE: hw/rtl/tab_stop_detab_entab.sv
// ----------------------------------------------------------------------------
// Tab stop detab/entab
// Expands tabs into spaces or compresses space runs into tabs on a
// character stream, tracking the output column against programmable stops.
// ----------------------------------------------------------------------------
// A character that is neither a tab nor a space in compress mode is accepted
// and then goes to the finish state, which hands its words to the output
// buffer. A tab, or a space in compress mode, runs a sequencer between accept
// and finish: it scans the stops in use for the furthest explicit stop, runs a
// bit-serial remainder to place the repeating stops when the first candidate
// lies at or past that stop, then tests candidate columns one after another
// until a stop is found or the search limit is reached (for a space, only the
// first candidate). The input is not ready while a character is being worked
// on. Up to two result words are buffered, so the next character is taken
// while earlier words still drain. When it has words to load, its finish
// state is held until the buffer is empty, so a stalled output stalls the
// input as well.
// ----------------------------------------------------------------------------
module tab_stop_detab_entab #(
    parameter int MAX_STOPS  = tsde_pkg::MAX_STOPS_DEF,
    parameter int MAX_COLUMN = tsde_pkg::MAX_COLUMN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // ch
    input  logic                                s_tlast,   // end_of_line
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // out_char, repeat_res
    output logic                                m_tlast,   // last
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tsde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsde_pkg::CFG_DAT_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FAR,
        ST_DIV,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [7:0] repeat_res;
        logic       last;
    } res_t;

    state_t                          state_reg;
    logic                            mode_reg;
    logic [7:0]                      interval_reg;
    logic [3:0]                      stop_count_reg;
    logic [tsde_pkg::CFG_DAT_W-1:0]  stop_columns_reg;
    logic [7:0]                      tab_char_reg;
    logic [tsde_pkg::COL_W-1:0]      column_reg;
    logic [7:0]                      pending_reg;

    logic [7:0]                      ch_reg;
    logic                            eol_reg;
    logic                            sp_reg;
    logic                            at_stop_reg;
    logic [tsde_pkg::CFG_DAT_W-1:0]  sh_reg;
    logic [3:0]                      cnt_reg;
    logic [7:0]                      far_reg;
    logic [tsde_pkg::CAND_W-1:0]     col_reg;
    logic [tsde_pkg::CAND_W-1:0]     dvd_reg;
    logic [7:0]                      phase_reg;
    logic [7:0]                      k_reg;

    res_t                            e0_reg;
    res_t                            e1_reg;
    logic [1:0]                      buf_cnt_reg;

    logic [3:0]                      n_eff;
    logic [7:0]                      iv;
    logic [MAX_STOPS-1:0]            hit_vec;
    logic                            stop_now;
    logic                            in_nl;
    logic                            in_tab;
    logic                            in_sp;
    logic [tsde_pkg::CAND_W-1:0]     div_trial;
    logic [8:0]                      phase_inc;
    logic [tsde_pkg::CAND_W-1:0]     col_start;

    logic                            f_nl;
    logic                            f_tab;
    logic                            f_sp;
    logic                            has_main;
    logic                            do_flush;
    logic [7:0]                      main_char;
    logic [7:0]                      main_rep;
    logic [7:0]                      p_inc;
    logic [8:0]                      col_sum;
    logic [tsde_pkg::COL_W-1:0]      fin_col;
    logic [7:0]                      fin_pend;
    logic [1:0]                      fin_cnt;
    res_t                            fin_r0;
    res_t                            fin_r1;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (buf_cnt_reg != 2'd0);
    assign m_tdata   = {e0_reg.repeat_res, e0_reg.out_char};
    assign m_tlast   = e0_reg.last;

    assign n_eff = (stop_count_reg > 4'(MAX_STOPS)) ? 4'(MAX_STOPS) : stop_count_reg;
    assign iv    = (interval_reg == 8'd0) ? 8'd1 : interval_reg;

    for (genvar g = 0; g < MAX_STOPS; g++) begin : g_hit
        assign hit_vec[g] = (4'(g) < n_eff)
            && ({1'b0, stop_columns_reg[8*g +: 8]} == col_reg);
    end

    assign stop_now = (col_reg > 9'd1)
        && ((|hit_vec) || ((col_reg >= {1'b0, far_reg}) && (phase_reg == 8'd0)));

    assign in_nl  = (s_tdata == tsde_pkg::NL_CODE);
    assign in_tab = !in_nl && (s_tdata == tab_char_reg);
    assign in_sp  = !in_nl && !in_tab && (s_tdata == tsde_pkg::SPACE_CODE) && mode_reg;

    assign col_start = {1'b0, column_reg} + 9'd2;
    assign div_trial = {phase_reg, dvd_reg[tsde_pkg::CAND_W-1]};
    assign phase_inc = {1'b0, phase_reg} + 9'd1;

    assign f_nl  = (ch_reg == tsde_pkg::NL_CODE);
    assign f_tab = !f_nl && (ch_reg == tab_char_reg);
    assign f_sp  = !f_nl && !f_tab && (ch_reg == tsde_pkg::SPACE_CODE) && mode_reg;
    assign p_inc = (pending_reg == tsde_pkg::PEND_MAX) ? pending_reg : pending_reg + 8'd1;

    always_comb begin
        has_main  = 1'b1;
        do_flush  = 1'b1;
        main_char = ch_reg;
        main_rep  = 8'd1;
        fin_pend  = 8'd0;
        col_sum   = {1'b0, column_reg} + 9'd1;
        if (f_nl) begin
            main_char = tsde_pkg::NL_CODE;
            col_sum   = 9'd0;
        end else if (f_tab) begin
            col_sum = {1'b0, column_reg} + {1'b0, k_reg};
            if (!mode_reg) begin
                main_char = tsde_pkg::SPACE_CODE;
                main_rep  = k_reg;
            end else begin
                do_flush  = 1'b0;
                main_char = tab_char_reg;
            end
        end else if (f_sp) begin
            do_flush = 1'b0;
            if (at_stop_reg) begin
                main_char = tab_char_reg;
            end else if (eol_reg) begin
                main_char = tsde_pkg::SPACE_CODE;
                main_rep  = p_inc;
            end else begin
                has_main = 1'b0;
                fin_pend = p_inc;
            end
        end
        if (eol_reg) begin
            fin_col = '0;
        end else if (col_sum > 9'(MAX_COLUMN)) begin
            fin_col = tsde_pkg::COL_W'(MAX_COLUMN);
        end else begin
            fin_col = col_sum[tsde_pkg::COL_W-1:0];
        end
        fin_r1 = '{out_char: main_char, repeat_res: main_rep, last: 1'b1};
        if (do_flush && (pending_reg != 8'd0)) begin
            fin_r0  = '{out_char: tsde_pkg::SPACE_CODE, repeat_res: pending_reg,
                        last: !has_main};
            fin_cnt = has_main ? 2'd2 : 2'd1;
        end else begin
            fin_r0  = fin_r1;
            fin_cnt = has_main ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            mode_reg         <= 1'b0;
            interval_reg     <= tsde_pkg::IV_RESET;
            stop_count_reg   <= 4'd0;
            stop_columns_reg <= '0;
            tab_char_reg     <= tsde_pkg::TAB_RESET;
            column_reg       <= '0;
            pending_reg      <= 8'd0;
            buf_cnt_reg      <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tsde_pkg::REG_MODE:         mode_reg         <= cfg_data[0];
                    tsde_pkg::REG_TAB_INTERVAL: interval_reg     <= cfg_data[7:0];
                    tsde_pkg::REG_STOP_COUNT:   stop_count_reg   <= cfg_data[3:0];
                    tsde_pkg::REG_STOP_COLUMNS: stop_columns_reg <= cfg_data;
                    tsde_pkg::REG_TAB_CHAR:     tab_char_reg     <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                e0_reg      <= e1_reg;
                buf_cnt_reg <= buf_cnt_reg - 2'd1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ch_reg    <= s_tdata;
                        eol_reg   <= s_tlast;
                        sp_reg    <= in_sp;
                        sh_reg    <= stop_columns_reg;
                        cnt_reg   <= 4'd0;
                        far_reg   <= 8'd1;
                        col_reg   <= col_start;
                        k_reg     <= 8'd1;
                        phase_reg <= 8'd0;
                        state_reg <= (in_tab || in_sp) ? ST_FAR : ST_FINISH;
                    end
                end
                ST_FAR: begin
                    if (cnt_reg == n_eff) begin
                        dvd_reg <= col_reg - {1'b0, far_reg};
                        cnt_reg <= 4'd0;
                        state_reg <= (col_reg >= {1'b0, far_reg}) ? ST_DIV : ST_SEARCH;
                    end else begin
                        if (sh_reg[7:0] > far_reg) begin
                            far_reg <= sh_reg[7:0];
                        end
                        sh_reg  <= sh_reg >> 8;
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_DIV: begin
                    if (div_trial >= {1'b0, iv}) begin
                        phase_reg <= 8'(div_trial - {1'b0, iv});
                    end else begin
                        phase_reg <= div_trial[7:0];
                    end
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(tsde_pkg::CAND_W - 1)) begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (sp_reg || stop_now) begin
                        at_stop_reg <= stop_now;
                        state_reg   <= ST_FINISH;
                    end else if (k_reg == tsde_pkg::LAST_SEARCH_K) begin
                        k_reg     <= tsde_pkg::MAX_K;
                        state_reg <= ST_FINISH;
                    end else begin
                        k_reg   <= k_reg + 8'd1;
                        col_reg <= col_reg + 9'd1;
                        if (col_reg + 9'd1 == {1'b0, far_reg}) begin
                            phase_reg <= 8'd0;
                        end else if (phase_inc == {1'b0, iv}) begin
                            phase_reg <= 8'd0;
                        end else begin
                            phase_reg <= phase_inc[7:0];
                        end
                    end
                end
                ST_FINISH: begin
                    if ((fin_cnt == 2'd0) || (buf_cnt_reg == 2'd0)) begin
                        column_reg  <= fin_col;
                        pending_reg <= fin_pend;
                        if (fin_cnt != 2'd0) begin
                            e0_reg      <= fin_r0;
                            e1_reg      <= fin_r1;
                            buf_cnt_reg <= fin_cnt;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= tsde_pkg::COL_W'(MAX_COLUMN))
        else $error("column exceeds its saturation limit");

    a_buf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_cnt_reg <= 2'd2)
        else $error("result buffer overfilled");

    a_finish_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && fin_cnt != 2'd0 && buf_cnt_reg != 2'd0)
        |=> (state_reg == ST_FINISH))
        else $error("results loaded over a busy buffer");

    a_search_k: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (k_reg != 8'd0 && k_reg <= tsde_pkg::LAST_SEARCH_K))
        else $error("tab search count out of range");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start the sequencer");

endmodule

FILE: test/tab_stop_detab_entab_checker.sv
// ----------------------------------------------------------------------------
// Tab stop detab/entab checker
// Watches the character, result and register channels of the block. It keeps
// its own copy of the registers, the output column and the held-back spaces,
// works out the result words that each accepted character must produce, and
// compares every accepted result word, field by field, with the oldest one
// still due.
// ----------------------------------------------------------------------------
module tab_stop_detab_entab_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // ch
    input  logic                           s_tlast,   // end_of_line
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,   // out_char, repeat_res
    input  logic                           m_tlast,   // last
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tsde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsde_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                             error_count,
    output int                             words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_char;
        logic [7:0] run_len;
        logic       last;
    } char_run_t;

    char_run_t expected_runs[$];
    char_run_t step_runs[$];
    char_run_t want;

    logic        comp_mode    = 1'b0;
    logic [7:0]  tab_interval = tsde_pkg::IV_RESET;
    logic [3:0]  stop_count   = '0;
    logic [63:0] stop_cols    = '0;
    logic [7:0]  tab_code     = tsde_pkg::TAB_RESET;

    int column  = 0;
    int pending = 0;

    task automatic report_mismatch(input string what);
        if (error_count < 40) begin
            $display("%0t ns mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic bit stop_at(input int col);
        int used, far, spacing, k, s;
        used    = (int'(stop_count) > tsde_pkg::MAX_STOPS_DEF) ? tsde_pkg::MAX_STOPS_DEF
                                                               : int'(stop_count);
        far     = 1;
        spacing = (tab_interval == 8'd0) ? 1 : int'(tab_interval);
        if (col <= 1) return 1'b0;
        for (k = 0; k < used; k++) begin
            s = int'(stop_cols[8*k +: 8]);
            if (s > far) far = s;
            if (col == s) return 1'b1;
        end
        if (col < far) return 1'b0;
        return ((col - far) % spacing) == 0;
    endfunction

    function automatic int clamp_col(input int col);
        return (col > tsde_pkg::MAX_COLUMN_DEF) ? tsde_pkg::MAX_COLUMN_DEF : col;
    endfunction

    function automatic void add_run(input logic [7:0] c, input logic [7:0] n);
        char_run_t r;
        r.out_char = c;
        r.run_len  = n;
        r.last     = 1'b0;
        step_runs.push_back(r);
    endfunction

    function automatic void flush_spaces();
        if (pending != 0) begin
            add_run(tsde_pkg::SPACE_CODE, pending[7:0]);
            pending = 0;
        end
    endfunction

    function automatic void predict_char(input logic [7:0] ch, input logic eol);
        int  k;
        bit  at_stop;
        step_runs.delete();
        if (ch == tsde_pkg::NL_CODE) begin
            flush_spaces();
            add_run(tsde_pkg::NL_CODE, 8'd1);
            column = 0;
        end else if (ch == tab_code) begin
            k = 1;
            while (k < int'(tsde_pkg::MAX_K) && !stop_at(column + 1 + k)) k++;
            column = clamp_col(column + k);
            if (!comp_mode) begin
                flush_spaces();
                add_run(tsde_pkg::SPACE_CODE, k[7:0]);
            end else begin
                pending = 0;
                add_run(tab_code, 8'd1);
            end
        end else if (ch == tsde_pkg::SPACE_CODE && comp_mode) begin
            at_stop = stop_at(column + 2);
            column  = clamp_col(column + 1);
            if (pending < int'(tsde_pkg::PEND_MAX)) pending++;
            if (at_stop) begin
                pending = 0;
                add_run(tab_code, 8'd1);
            end
        end else begin
            flush_spaces();
            add_run(ch, 8'd1);
            column = clamp_col(column + 1);
        end
        if (eol) begin
            flush_spaces();
            column = 0;
        end
        if (step_runs.size() > 0) step_runs[$].last = 1'b1;
        foreach (step_runs[i]) expected_runs.push_back(step_runs[i]);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch($sformatf("unexpected word char=%0d len=%0d last=%0b",
                                              m_tdata[7:0], m_tdata[15:8], m_tlast));
                end else begin
                    want = expected_runs.pop_front();
                    if (m_tdata[7:0] !== want.out_char) begin
                        report_mismatch($sformatf("out_char %0d, expected %0d",
                                                  m_tdata[7:0], want.out_char));
                    end
                    if (m_tdata[15:8] !== want.run_len) begin
                        report_mismatch($sformatf("repeat_res %0d, expected %0d",
                                                  m_tdata[15:8], want.run_len));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_tlast, want.last));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tsde_pkg::REG_MODE:         comp_mode    = cfg_data[0];
                    tsde_pkg::REG_TAB_INTERVAL: tab_interval = cfg_data[7:0];
                    tsde_pkg::REG_STOP_COUNT:   stop_count   = cfg_data[3:0];
                    tsde_pkg::REG_STOP_COLUMNS: stop_cols    = cfg_data;
                    tsde_pkg::REG_TAB_CHAR:     tab_code     = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_char(s_tdata, s_tlast);
            end
            words_due = expected_runs.size();
        end
    end

endmodule

FILE: test/tab_stop_detab_entab_tb.sv
// ----------------------------------------------------------------------------
// Tab stop detab/entab testbench
// Drives a short directed character sequence at the reset settings, then ten
// phases of random lines under different register settings, in expand and in
// compress mode. The sender works in bursts and the receiver stalls on its own
// pattern. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tab_stop_detab_entab_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime CLK_PERIOD  = 12ns;
    localparam int      CYCLE_LIMIT = 2_000_000;
    localparam int      SETTLE_CYC  = 320;
    localparam int      PHASE_COUNT = 10;
    localparam int      PHASE_CHARS = 60;

    typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_style_t;

    typedef struct {
        logic        mode;
        logic [7:0]  interval;
        logic [3:0]  stop_count;
        logic [63:0] stops;
        logic [7:0]  tab_char;
    } tab_setting_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;   // ch
    logic                           s_tlast   = 1'b0; // end_of_line
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [15:0]                    m_tdata;          // out_char, repeat_res
    logic                           m_tlast;          // last
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tsde_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tsde_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    int         error_count;
    int         words_due;
    int         cycle_count = 0;
    int         burst_left  = 0;
    bit         tx_steady   = 1'b0;
    int         chars_sent  = 0;
    logic [7:0] cur_tab     = tsde_pkg::TAB_RESET;
    rx_style_t  rx_style    = RX_OPEN;
    int         stall_left  = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    tab_stop_detab_entab u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tab_stop_detab_entab_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .words_due   (words_due)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycle_count % 256 == 0) rx_style = rx_style_t'($urandom_range(0, 2));
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_OPEN: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(1, 24);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic eol);
        int gap;
        if (burst_left == 0) begin
            gap = tx_steady ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_line(input int len);
        int         i, pick;
        logic [7:0] c;
        logic       eol;
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      c = tsde_pkg::SPACE_CODE;
            else if (pick < 50) c = cur_tab;
            else if (pick < 90) c = 8'($urandom_range(33, 126));
            else if (pick < 97) c = 8'($urandom_range(0, 255));
            else                c = tsde_pkg::NL_CODE;
            if (i == len - 1) begin
                eol = 1'($urandom_range(0, 1));
                if (!eol) c = tsde_pkg::NL_CODE;
            end else begin
                eol = ($urandom_range(0, 63) == 0);
            end
            send_char(c, eol);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [tsde_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsde_pkg::CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_regs(input tab_setting_t set);
        put_reg(tsde_pkg::REG_MODE, 64'(set.mode));
        put_reg(tsde_pkg::REG_TAB_INTERVAL, 64'(set.interval));
        put_reg(tsde_pkg::REG_STOP_COUNT, 64'(set.stop_count));
        put_reg(tsde_pkg::REG_STOP_COLUMNS, set.stops);
        put_reg(tsde_pkg::REG_TAB_CHAR, 64'(set.tab_char));
        cfg_valid <= 1'b0;
        cur_tab = set.tab_char;
    endtask

    function automatic tab_setting_t phase_setting(input int p);
        tab_setting_t s;
        int           k;
        s.mode       = 1'b1;
        s.interval   = tsde_pkg::IV_RESET;
        s.stop_count = '0;
        s.stops      = {$urandom, $urandom};
        s.tab_char   = tsde_pkg::TAB_RESET;
        case (p)
            0: s.mode = 1'b0;
            1: begin
                s.interval   = 8'd4;
                s.stop_count = 4'd3;
                for (k = 0; k < 8; k++) s.stops[8*k +: 8] = 8'($urandom_range(2, 40));
            end
            2: s.interval = 8'd255;
            3: begin
                s.mode       = 1'b0;
                s.interval   = 8'd1;
                s.stop_count = 4'd8;
            end
            4: begin
                s.interval   = 8'd0;
                s.stop_count = 4'd15;
                s.tab_char   = tsde_pkg::SPACE_CODE;
            end
            5: begin
                s.interval   = 8'd3;
                s.stop_count = 4'd8;
                for (k = 2; k < 8; k++) s.stops[8*k +: 8] = 8'($urandom_range(2, 60));
                s.stops[15:0] = 16'h0100;
                s.tab_char    = tsde_pkg::NL_CODE;
            end
            6: begin
                s.mode        = 1'b0;
                s.interval    = 8'd255;
                s.stop_count  = 4'd1;
                s.stops[7:0]  = 8'd255;
                s.tab_char    = 8'd0;
            end
            7: begin
                s.stop_count = 4'd2;
                s.tab_char   = 8'd255;
            end
            default: begin
                s.mode       = 1'($urandom_range(0, 1));
                s.interval   = 8'($urandom_range(1, 16));
                s.stop_count = 4'($urandom_range(0, 8));
                for (k = 0; k < 8; k++) s.stops[8*k +: 8] = 8'($urandom_range(0, 48));
            end
        endcase
        return s;
    endfunction

    initial begin
        tab_setting_t setting;
        int           p, target, len;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_char("a", 1'b0);
        send_char(tsde_pkg::TAB_RESET, 1'b0);
        send_char(8'd0, 1'b0);
        send_char(8'd255, 1'b0);
        send_char(tsde_pkg::SPACE_CODE, 1'b0);
        send_char(tsde_pkg::NL_CODE, 1'b0);
        send_char(tsde_pkg::TAB_RESET, 1'b1);
        send_char("b", 1'b1);

        settle();
        setting.mode       = 1'b1;
        setting.interval   = tsde_pkg::IV_RESET;
        setting.stop_count = '0;
        setting.stops      = '0;
        setting.tab_char   = tsde_pkg::TAB_RESET;
        program_regs(setting);
        repeat (8) send_char(tsde_pkg::SPACE_CODE, 1'b0);
        send_char(tsde_pkg::SPACE_CODE, 1'b0);
        send_char(tsde_pkg::SPACE_CODE, 1'b0);
        send_char("x", 1'b0);
        send_char(tsde_pkg::TAB_RESET, 1'b0);
        send_char(tsde_pkg::SPACE_CODE, 1'b0);
        send_char(tsde_pkg::SPACE_CODE, 1'b0);
        send_char(tsde_pkg::TAB_RESET, 1'b0);
        send_char(tsde_pkg::SPACE_CODE, 1'b1);
        send_char(tsde_pkg::SPACE_CODE, 1'b0);
        send_char(tsde_pkg::SPACE_CODE, 1'b0);

        for (p = 0; p < PHASE_COUNT; p++) begin
            settle();
            setting = phase_setting(p);
            program_regs(setting);
            tx_steady = ($urandom_range(0, 2) == 0);
            target    = chars_sent + PHASE_CHARS;
            if (p == 2) begin
                // One tab saturates the column, then enough spaces to saturate the
                // held-back count before a printing character flushes them.
                send_char(cur_tab, 1'b0);
                repeat (258) send_char(tsde_pkg::SPACE_CODE, 1'b0);
                send_char("x", 1'b1);
            end
            while (chars_sent < target) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 300)
                                                   : $urandom_range(1, 30);
                if (len > target - chars_sent) len = target - chars_sent;
                send_line(len);
            end
        end

        settle();
        if (error_count == 0 && words_due == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
